>>> sv/gbis_pkg.sv
// shared types and constants for the grid bracket index search core
// no dependencies; compiled before every other file
package gbis_pkg;

    localparam int GBIS_AXIS_DEPTH = 1024;
    localparam int IDX_W           = 10;
    localparam int VAL_W           = 31;
    localparam int CNT_W           = 11;
    localparam int OP_W            = 2;
    localparam int CFG_IDX_W       = 1;

    localparam logic [OP_W-1:0] OP_WRITE_LAT = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_LON = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LAT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LON_COUNT = 1'd1;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_FWD,
        SCAN_REV,
        SCAN_DONE
    } scan_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_BUSY
    } top_state_t;

    typedef struct packed {
        logic start;
        logic take;
    } scan_ctl_t;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } scan_stat_t;

endpackage

>>> sv/gbis_if.sv
// valid/ready channel interfaces for requests and results
// depends on gbis_pkg
interface gbis_req_if;
    import gbis_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] query_lat;
    logic signed [VAL_W-1:0] query_lon;

    modport source (
        output valid, operation, entry_index, entry_value, query_lat, query_lon,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, entry_value, query_lat, query_lon,
        output ready
    );
endinterface

interface gbis_rsp_if;
    import gbis_pkg::*;

    logic             valid;
    logic             ready;
    logic             in_bounds;
    logic [IDX_W-1:0] lat_low_index;
    logic [IDX_W-1:0] lat_high_index;
    logic [IDX_W-1:0] lon_low_index;
    logic [IDX_W-1:0] lon_high_index;

    modport source (
        output valid, in_bounds, lat_low_index, lat_high_index,
               lon_low_index, lon_high_index,
        input  ready
    );
    modport sink (
        input  valid, in_bounds, lat_low_index, lat_high_index,
               lon_low_index, lon_high_index,
        output ready
    );
endinterface

>>> sv/grid_bracket_index_search_core.sv
// top level of the grid bracket index search core: request sequencer,
// count registers and result register around two axis scan units
// depends on gbis_pkg, gbis_if, gbis_axis_scan
//
// usage
// - req channel carries one transaction per operation: write latitude
//   entry, write longitude entry, or query a point; code 3 is dropped
// - rsp channel returns one transaction per query, nothing for writes
// - cfg port (cfg_we, cfg_index, cfg_data) sets lat_count and lon_count;
//   write it only while no query is in flight
// - a write stores its entry in that axis memory; a query scans both axes
//   side by side, one entry per cycle, then loads the result register once
//   both axes are done, and rsp.valid comes straight from that register
// - one query is in flight at a time; req.ready returns the cycle after the
//   result register loads and stays high even while that result waits on rsp
// - if rsp stalls, the finished query waits in the scan units until the
//   result register frees up
// - reset clears counts, sequencer and result valid; axis memories are
//   undefined until written, so query only entries already written
module grid_bracket_index_search_core #(
    parameter int AXIS_DEPTH = gbis_pkg::GBIS_AXIS_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbis_pkg::CNT_W-1:0]      cfg_data,
    gbis_req_if.sink                        req,
    gbis_rsp_if.source                      rsp
);
    import gbis_pkg::*;

    // configuration registers
    logic [CNT_W-1:0] lat_count_reg;
    logic [CNT_W-1:0] lon_count_reg;

    // sequencer
    top_state_t state_reg, state_next;
    logic       accept;
    logic       lat_wr;
    logic       lon_wr;
    logic       start_query;
    logic       finish;

    // scan unit links
    scan_ctl_t  scan_ctl;
    scan_stat_t lat_stat;
    scan_stat_t lon_stat;

    // result register
    logic             out_valid_reg;
    logic             in_bounds_reg;
    logic [IDX_W-1:0] lat_lo_reg;
    logic [IDX_W-1:0] lat_hi_reg;
    logic [IDX_W-1:0] lon_lo_reg;
    logic [IDX_W-1:0] lon_hi_reg;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_count_reg <= '0;
            lon_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAT_COUNT: lat_count_reg <= cfg_data;
                REG_LON_COUNT: lon_count_reg <= cfg_data;
                default:       lat_count_reg <= lat_count_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE:
            begin
                if (accept && (req.operation == OP_QUERY))
                begin
                    state_next = TOP_BUSY;
                end
            end
            TOP_BUSY:
            begin
                if (lat_stat.done && lon_stat.done && out_free)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready   = 1'b0;
        lat_wr      = 1'b0;
        lon_wr      = 1'b0;
        start_query = 1'b0;
        finish      = 1'b0;
        unique case (state_reg)
            TOP_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    unique case (req.operation)
                        OP_WRITE_LAT: lat_wr      = 1'b1;
                        OP_WRITE_LON: lon_wr      = 1'b1;
                        OP_QUERY:     start_query = 1'b1;
                        default:      start_query = 1'b0;
                    endcase
                end
            end
            TOP_BUSY:
            begin
                finish = lat_stat.done && lon_stat.done && out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TOP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign scan_ctl.start = start_query;
    assign scan_ctl.take  = finish;

    gbis_axis_scan #(
        .AXIS_DEPTH (AXIS_DEPTH)
    ) u_lat_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (lat_wr),
        .wr_addr (req.entry_index),
        .wr_data (req.entry_value),
        .count   (lat_count_reg),
        .query   (req.query_lat),
        .ctl     (scan_ctl),
        .stat    (lat_stat)
    );

    gbis_axis_scan #(
        .AXIS_DEPTH (AXIS_DEPTH)
    ) u_lon_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (lon_wr),
        .wr_addr (req.entry_index),
        .wr_data (req.entry_value),
        .count   (lon_count_reg),
        .query   (req.query_lon),
        .ctl     (scan_ctl),
        .stat    (lon_stat)
    );

    // result register: load on finish, drop when the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            in_bounds_reg <= lat_stat.ok && lon_stat.ok;
            lat_lo_reg    <= lat_stat.lo;
            lat_hi_reg    <= lat_stat.hi;
            lon_lo_reg    <= lon_stat.lo;
            lon_hi_reg    <= lon_stat.hi;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.in_bounds      = in_bounds_reg;
    assign rsp.lat_low_index  = lat_lo_reg;
    assign rsp.lat_high_index = lat_hi_reg;
    assign rsp.lon_low_index  = lon_lo_reg;
    assign rsp.lon_high_index = lon_hi_reg;

endmodule

>>> sv/gbis_axis_scan.sv
// one coordinate axis: entry memory plus forward/reverse bracket scan
// depends on gbis_pkg
module gbis_axis_scan #(
    parameter int AXIS_DEPTH = gbis_pkg::GBIS_AXIS_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [gbis_pkg::IDX_W-1:0]        wr_addr,
    input  logic signed [gbis_pkg::VAL_W-1:0] wr_data,
    input  logic [gbis_pkg::CNT_W-1:0]        count,
    input  logic signed [gbis_pkg::VAL_W-1:0] query,
    input  gbis_pkg::scan_ctl_t               ctl,
    output gbis_pkg::scan_stat_t              stat
);
    import gbis_pkg::*;

    localparam int AW = (AXIS_DEPTH > 1) ? $clog2(AXIS_DEPTH) : 1;
    localparam int NW = AW + 1;

    logic signed [VAL_W-1:0] mem [AXIS_DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    scan_state_t             state_reg, state_next;
    logic signed [VAL_W-1:0] q_reg, q_next;
    logic [AW-1:0]           last_reg, last_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    ok_reg, ok_next;
    logic [IDX_W-1:0]        lo_reg, lo_next;
    logic [IDX_W-1:0]        hi_reg, hi_next;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr_aw;
    logic          wr_in_range;
    logic [NW-1:0] usable;
    logic          hit;
    logic          at_first;
    logic          at_last;

    assign wr_in_range = (32'(wr_addr) < AXIS_DEPTH);
    assign wr_addr_aw  = AW'(wr_addr);
    assign usable      = (32'(count) > AXIS_DEPTH) ? NW'(AXIS_DEPTH) : NW'(count);
    assign hit         = (rd_data_reg >= q_reg);
    assign at_first    = (rd_idx_reg == '0);
    assign at_last     = (rd_idx_reg == last_reg);

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_addr_aw] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SCAN_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = (count == '0) ? SCAN_DONE : SCAN_FWD;
                end
            end
            SCAN_FWD:
            begin
                if (hit)
                begin
                    state_next = at_first ? SCAN_REV : SCAN_DONE;
                end
                else if (at_last)
                begin
                    state_next = SCAN_DONE;
                end
            end
            SCAN_REV:
            begin
                if (hit || at_first)
                begin
                    state_next = SCAN_DONE;
                end
            end
            SCAN_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = SCAN_IDLE;
                end
            end
            default: state_next = SCAN_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr   = rd_idx_reg;
        q_next    = q_reg;
        last_next = last_reg;
        ok_next   = ok_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        unique case (state_reg)
            SCAN_IDLE:
            begin
                if (ctl.start)
                begin
                    q_next    = query;
                    last_next = AW'(usable - 1'b1);
                    rd_addr   = '0;
                    ok_next   = 1'b0;
                    lo_next   = '0;
                    hi_next   = '0;
                end
            end
            SCAN_FWD:
            begin
                if (hit)
                begin
                    if (at_first)
                    begin
                        rd_addr = last_reg;
                    end
                    else
                    begin
                        ok_next = 1'b1;
                        lo_next = IDX_W'(rd_idx_reg - 1'b1);
                        hi_next = IDX_W'(rd_idx_reg);
                    end
                end
                else if (!at_last)
                begin
                    rd_addr = rd_idx_reg + 1'b1;
                end
            end
            SCAN_REV:
            begin
                if (hit)
                begin
                    if (!at_last)
                    begin
                        ok_next = 1'b1;
                        lo_next = IDX_W'(rd_idx_reg);
                        hi_next = IDX_W'({1'b0, rd_idx_reg} + 1'b1);
                    end
                end
                else if (!at_first)
                begin
                    rd_addr = rd_idx_reg - 1'b1;
                end
            end
            SCAN_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        rd_idx_next = rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        last_reg   <= last_next;
        rd_idx_reg <= rd_idx_next;
        ok_reg     <= ok_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

    assign stat.done = (state_reg == SCAN_DONE);
    assign stat.ok   = ok_reg;
    assign stat.lo   = ok_reg ? lo_reg : '0;
    assign stat.hi   = ok_reg ? hi_reg : '0;

endmodule
